// ----- src/lfx_pkg.sv -----
// Shared types and constants for the light effect generator.
// No dependencies; imported by every module of the block.
package lfx_pkg;

  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned TICK_W      = 17;
  localparam int unsigned LVL_REG_W   = 10;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned LEVEL_MAX   = 255;
  localparam int unsigned GLOW_STEP   = 8;
  localparam int unsigned PHASE_STEPS = 12;
  localparam int unsigned PHASE_LAST  = 63;
  localparam int unsigned FIRE_RELOAD = 4;

  // bit-serial multiply: MUL_A_W steps, divide: DIV_N_W steps
  localparam int unsigned MUL_A_W     = LEVEL_W;
  localparam int unsigned MUL_B_W     = TIME_W;
  localparam int unsigned PROD_W      = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_STEPS   = MUL_A_W;
  localparam int unsigned MUL_CNT_W   = $clog2(MUL_STEPS);
  localparam int unsigned DIV_N_W     = PROD_W;
  localparam int unsigned DIV_D_W     = TIME_W;
  localparam int unsigned DIV_STEPS   = DIV_N_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  typedef enum logic [MODE_W-1:0] {
    MODE_FIRE    = 3'd0,
    MODE_FLICKER = 3'd1,
    MODE_FLASH   = 3'd2,
    MODE_STROBE  = 3'd3,
    MODE_GLOW    = 3'd4,
    MODE_FADE    = 3'd5,
    MODE_PHASED  = 3'd6
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE          = 3'd0,
    REG_UPPER_LEVEL   = 3'd1,
    REG_LOWER_LEVEL   = 3'd2,
    REG_UPPER_TIME    = 3'd3,
    REG_LOWER_TIME    = 3'd4,
    REG_INITIAL_COUNT = 3'd5,
    REG_INITIAL_LIGHT = 3'd6,
    REG_ONE_SHOT      = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic               restart;
    logic [LEVEL_W-1:0] random_byte;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] light_level;
    logic               finished;
  } out_item_t;

endpackage

// ----- src/lfx_mul.sv -----
// Bit-serial unsigned multiplier, one multiplier bit per cycle, MSB first.
// Depends on lfx_pkg.
module lfx_mul import lfx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic               done_o,
  output logic [PROD_W-1:0]  prod_o
);

  logic [MUL_A_W-1:0]   a_q;
  logic [MUL_B_W-1:0]   b_q;
  logic [PROD_W-1:0]    acc_q, acc_d;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic                 run_q, done_q, last;

  assign last  = (cnt_q == MUL_CNT_W'(MUL_STEPS - 1));
  assign acc_d = {acc_q[PROD_W-2:0], 1'b0} +
                 (a_q[MUL_A_W-1] ? PROD_W'(b_q) : PROD_W'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && last;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + MUL_CNT_W'(1);
        if (last) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (run_q) begin
      a_q   <= {a_q[MUL_A_W-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- src/lfx_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on lfx_pkg.
module lfx_div import lfx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] num_i,
  input  logic [DIV_D_W-1:0] dvs_i,
  output logic               done_o,
  output logic [DIV_N_W-1:0] quo_o
);

  logic [DIV_N_W-1:0]   quo_q;
  logic [DIV_D_W-1:0]   rem_q, dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 run_q, done_q, last;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W+1:0]   diff;
  logic                 ge;

  assign last  = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign trial = {rem_q, quo_q[DIV_N_W-1]};
  assign diff  = {1'b0, trial} - {2'b0, dvs_q};
  assign ge    = !diff[DIV_D_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && last;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (last) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      dvs_q <= dvs_i;
    end else if (run_q) begin
      quo_q <= {quo_q[DIV_N_W-2:0], ge};
      rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- src/light_effect_generator.sv -----
// Light effect generator: one item in, one light level out. Every transfer in gives
// exactly one transfer out. Restart and the fire, flicker, flash, strobe, glow and
// unused modes go from ST_EXEC straight to ST_OUT, which loads the output register
// once it is free; fade and phased items pass ST_EXEC, ST_MUL and ST_DIV first, which
// run the bit-serial 8-step multiply and the 24-step restoring divide that form
// (diff * tick) / span. A fade step that ends or holds a one-shot fade takes the short path.
// One item is in flight at a time; the output register lets the next item be taken
// while a result still waits. Configuration is written through cfg_we_i/cfg_idx_i.
// Depends on lfx_pkg, lfx_mul and lfx_div.
module light_effect_generator import lfx_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o
);

  // configuration
  logic [MODE_W-1:0]  mode_q;
  logic [LEVEL_W-1:0] upper_level_q, lower_level_q, initial_light_q;
  logic [TIME_W-1:0]  upper_time_q, lower_time_q, initial_count_q;
  logic               one_shot_q;

  // effect state
  logic [TICK_W-1:0]           tick_q, tick_d;
  logic signed [LVL_REG_W-1:0] lvl_q, lvl_d;
  logic                        glow_q, glow_d;
  logic [LEVEL_W-1:0]          from_q, from_d, to_q, to_d;
  logic                        done_q, done_d;

  // control
  state_e             state_q, state_d;
  in_item_t           in_q;
  logic               launch, mul_start, div_start, out_load;
  logic               mul_done, div_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [DIV_N_W-1:0] quo;
  logic               sgn_q, sgn_d;
  logic [LEVEL_W-1:0] base_q, base_d;
  logic [DIV_D_W-1:0] dvs_q, dvs_d;
  logic               out_valid_q;
  out_item_t          out_item_q, out_item_d;

  function automatic logic signed [LVL_REG_W-1:0] sat10(input logic signed [25:0] v);
    logic signed [LVL_REG_W-1:0] r;
    if (v < -26'sd512) begin
      r = -10'sd512;
    end else if (v > 26'sd511) begin
      r = 10'sd511;
    end else begin
      r = v[LVL_REG_W-1:0];
    end
    return r;
  endfunction

  // ---------------- configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= MODE_FIRE;
      upper_level_q   <= LEVEL_W'(LEVEL_MAX);
      lower_level_q   <= '0;
      upper_time_q    <= TIME_W'(1);
      lower_time_q    <= TIME_W'(1);
      initial_count_q <= TIME_W'(1);
      initial_light_q <= LEVEL_W'(LEVEL_MAX);
      one_shot_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:          mode_q          <= cfg_wdata_i[MODE_W-1:0];
        REG_UPPER_LEVEL:   upper_level_q   <= cfg_wdata_i[LEVEL_W-1:0];
        REG_LOWER_LEVEL:   lower_level_q   <= cfg_wdata_i[LEVEL_W-1:0];
        REG_UPPER_TIME:    upper_time_q    <= cfg_wdata_i[TIME_W-1:0];
        REG_LOWER_TIME:    lower_time_q    <= cfg_wdata_i[TIME_W-1:0];
        REG_INITIAL_COUNT: initial_count_q <= cfg_wdata_i[TIME_W-1:0];
        REG_INITIAL_LIGHT: initial_light_q <= cfg_wdata_i[LEVEL_W-1:0];
        REG_ONE_SHOT:      one_shot_q      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- shared arithmetic
  logic signed [10:0] l11, hi11, lo11, amt11, fall1, rise1;
  logic [TICK_W-1:0]  tick_dec;
  logic               dec_zero;

  assign l11      = 11'(lvl_q);
  assign hi11     = signed'({3'b0, upper_level_q});
  assign lo11     = signed'({3'b0, lower_level_q});
  assign amt11    = signed'({5'b0, in_q.random_byte[1:0], 4'b0});
  assign tick_dec = tick_q - TICK_W'(1);
  assign dec_zero = (tick_dec == '0);
  assign fall1    = 11'(sat10(26'(l11 - signed'(11'(GLOW_STEP)))));
  assign rise1    = 11'(sat10(26'(l11 + signed'(11'(GLOW_STEP)))));

  // fade
  logic [TIME_W-1:0]  span;
  logic signed [17:0] t18, span18, tn18;
  logic               fd_ge;
  logic [LEVEL_W-1:0] fd_from, fd_to;
  logic signed [8:0]  fd_diff;
  logic [TIME_W-1:0]  tn_abs;
  logic [LEVEL_W-1:0] diff_abs;

  assign span     = (upper_time_q == '0) ? TIME_W'(1) : upper_time_q;
  assign t18      = 18'(signed'(tick_q));
  assign span18   = signed'({2'b0, span});
  assign fd_ge    = (t18 >= span18);
  assign tn18     = fd_ge ? (t18 + 18'sd1 - span18) : (t18 + 18'sd1);
  assign fd_from  = fd_ge ? to_q : from_q;
  assign fd_to    = fd_ge ? from_q : to_q;
  assign fd_diff  = signed'({1'b0, fd_to}) - signed'({1'b0, fd_from});
  assign tn_abs   = tn18[17] ? TIME_W'(-tn18) : tn18[TIME_W-1:0];
  assign diff_abs = fd_diff[8] ? LEVEL_W'(-fd_diff) : fd_diff[LEVEL_W-1:0];

  // phased
  logic [MUL_B_W-1:0] ph_k;
  logic [TICK_W-1:0]  ph_next;

  always_comb begin
    if (tick_q < TICK_W'(PHASE_STEPS)) begin
      ph_k = MUL_B_W'(tick_q);
    end else if (tick_q < TICK_W'(2 * PHASE_STEPS)) begin
      ph_k = MUL_B_W'(TICK_W'(2 * PHASE_STEPS - 1) - tick_q);
    end else begin
      ph_k = '0;
    end
  end

  assign ph_next = (tick_q == '0) ? TICK_W'(PHASE_LAST) : tick_dec;

  // final level after divide: sign, add base, saturate
  logic signed [25:0] q26, fin26;
  assign q26   = signed'({2'b0, quo});
  assign fin26 = (sgn_q ? -q26 : q26) + signed'({18'b0, base_q});

  // ---------------- per-item step
  always_comb begin
    tick_d = tick_q;
    lvl_d  = lvl_q;
    glow_d = glow_q;
    from_d = from_q;
    to_d   = to_q;
    done_d = done_q;
    sgn_d  = sgn_q;
    base_d = base_q;
    dvs_d  = dvs_q;
    mul_a  = '0;
    mul_b  = '0;
    launch = 1'b0;
    if (in_q.restart) begin
      tick_d = (mode_q == MODE_FADE) ? (TICK_W'(initial_count_q) - TICK_W'(1))
                                     : TICK_W'(initial_count_q);
      lvl_d  = signed'({2'b0, initial_light_q});
      glow_d = 1'b0;
      from_d = upper_level_q;
      to_d   = lower_level_q;
      done_d = 1'b0;
    end else begin
      case (mode_q)
        MODE_FIRE: begin
          tick_d = tick_dec;
          if (dec_zero) begin
            if (l11 - amt11 < lo11) begin
              lvl_d = 10'(lo11);
            end else begin
              lvl_d = sat10(26'(hi11 - amt11));
            end
            tick_d = TICK_W'(FIRE_RELOAD);
          end
        end
        MODE_FLICKER: begin
          if (tick_q != '0) begin
            tick_d = tick_dec;
          end else if (l11 == hi11) begin
            lvl_d  = 10'(lo11);
            tick_d = TICK_W'(in_q.random_byte[2:0]) + TICK_W'(1);
          end else begin
            lvl_d  = 10'(hi11);
            tick_d = TICK_W'(in_q.random_byte[4:0]) + TICK_W'(1);
          end
        end
        MODE_FLASH: begin
          tick_d = tick_dec;
          if (dec_zero) begin
            if (l11 == hi11) begin
              lvl_d  = 10'(lo11);
              tick_d = TICK_W'(in_q.random_byte & lower_time_q[LEVEL_W-1:0]) + TICK_W'(1);
            end else begin
              lvl_d  = 10'(hi11);
              tick_d = TICK_W'(in_q.random_byte & upper_time_q[LEVEL_W-1:0]) + TICK_W'(1);
            end
          end
        end
        MODE_STROBE: begin
          tick_d = tick_dec;
          if (dec_zero) begin
            if (l11 == lo11) begin
              lvl_d  = 10'(hi11);
              tick_d = TICK_W'(upper_time_q);
            end else begin
              lvl_d  = 10'(lo11);
              tick_d = TICK_W'(lower_time_q);
            end
          end
        end
        MODE_GLOW: begin
          if (!glow_q) begin
            lvl_d = 10'(fall1);
            if (fall1 <= lo11) begin
              lvl_d  = sat10(26'(fall1 + signed'(11'(GLOW_STEP))));
              glow_d = 1'b1;
            end
          end else begin
            lvl_d = 10'(rise1);
            if (rise1 >= hi11) begin
              lvl_d  = sat10(26'(rise1 - signed'(11'(GLOW_STEP))));
              glow_d = 1'b0;
            end
          end
        end
        MODE_FADE: begin
          if (!done_q) begin
            if (fd_ge && one_shot_q) begin
              lvl_d  = signed'({2'b0, to_q});
              done_d = 1'b1;
            end else begin
              tick_d = tn18[TICK_W-1:0];
              from_d = fd_from;
              to_d   = fd_to;
              mul_a  = diff_abs;
              mul_b  = tn_abs;
              sgn_d  = fd_diff[8] ^ tn18[17];
              base_d = fd_from;
              dvs_d  = span;
              launch = 1'b1;
            end
          end
        end
        MODE_PHASED: begin
          tick_d = ph_next;
          mul_a  = LEVEL_W'(LEVEL_MAX) - lower_level_q;
          mul_b  = ph_k;
          sgn_d  = 1'b0;
          base_d = lower_level_q;
          dvs_d  = DIV_D_W'(PHASE_STEPS);
          launch = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // ---------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (launch) begin
          mul_start = 1'b1;
          state_d   = ST_MUL;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      in_q <= in_item_i;
    end
    if (state_q == ST_EXEC) begin
      sgn_q  <= sgn_d;
      base_q <= base_d;
      dvs_q  <= dvs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      lvl_q  <= '0;
      glow_q <= 1'b0;
      from_q <= '0;
      to_q   <= '0;
      done_q <= 1'b0;
    end else if (state_q == ST_EXEC) begin
      tick_q <= tick_d;
      lvl_q  <= lvl_d;
      glow_q <= glow_d;
      from_q <= from_d;
      to_q   <= to_d;
      done_q <= done_d;
    end else if (div_done) begin
      lvl_q <= sat10(fin26);
    end
  end

  lfx_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  lfx_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod),
    .dvs_i   (dvs_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // ---------------- output register
  always_comb begin
    if (lvl_q < 10'sd0) begin
      out_item_d.light_level = '0;
    end else if (lvl_q > 10'sd255) begin
      out_item_d.light_level = LEVEL_W'(LEVEL_MAX);
    end else begin
      out_item_d.light_level = lvl_q[LEVEL_W-1:0];
    end
    out_item_d.finished = (mode_q == MODE_FADE) && !in_q.restart && done_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_MUL)
    else $error("multiplier finished outside the multiply phase");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_done_only_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(mode_q == MODE_FADE && !in_q.restart))
    else $error("fade finished flag set outside fade mode");

  a_glow_only_glow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(glow_q) |-> $past(mode_q == MODE_GLOW || in_q.restart))
    else $error("glow direction changed outside glow mode");
`endif

endmodule
